// File: rtl/assert_macros.svh
// Assertion macros shared by the stereo mix block.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SMDB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/smdb_pkg.sv
// Shared types, constants and microcode ROM for the stereo mix block.
// No dependencies; used by smdb_seq, smdb_datapath and the top level.
package smdb_pkg;

  localparam int PC_W   = 5;
  localparam int DATA_W = 32;
  localparam int COEF_W = 18;
  localparam int MB_W   = 24;
  localparam int PROD_W = 48;
  localparam int MIX_W  = 17;
  localparam int SMP_W  = 16;
  localparam int PSG_W  = 15;
  localparam int PCT_W  = 7;

  localparam logic [PC_W-1:0] PC_MAIN = PC_W'(9);
  localparam logic [PC_W-1:0] PC_MUTE = PC_W'(23);
  localparam logic [PC_W-1:0] PC_LAST = PC_W'(23);

  // Multiplier B-side constants
  localparam logic signed [MB_W-1:0] K_DCB_POLE = 24'sd65208;   // 0xFEB8
  localparam logic signed [MB_W-1:0] K_RECIP    = 24'sd2684355; // ceil(2^26/25)
  localparam logic signed [MB_W-1:0] K_B0_SPAN  = 24'sd57856;   // 0x10000 - 0x1E00
  localparam logic signed [MB_W-1:0] K_B1       = 24'sd15360;   // 0x3C00
  localparam logic signed [MB_W-1:0] K_B2       = 24'sd7680;    // 0x1E00
  localparam logic signed [MB_W-1:0] K_A1       = -24'sd24576;  // -0x6000
  localparam logic signed [MB_W-1:0] K_A2       = 24'sd1024;    // 0x0400

  localparam logic signed [DATA_W-1:0] K_B0      = 32'sd7680;
  localparam logic signed [DATA_W-1:0] K_ONE     = 32'sd65536;
  localparam logic signed [MIX_W-1:0]  K_PSG_MID = 17'sd16384;

  typedef enum logic [1:0] {
    CFG_FM_ENABLE  = 2'd0,
    CFG_PSG_ENABLE = 2'd1,
    CFG_FILTER_PCT = 2'd2
  } cfg_idx_t;

  typedef enum logic {SQ_IDLE, SQ_RUN} seq_state_t;

  typedef enum logic [2:0] {
    SEQ_NEXT, SEQ_JMP_MUTE, SEQ_JMP_COEF, SEQ_DONE, SEQ_DONE_ZERO
  } seq_op_t;

  typedef enum logic [3:0] {
    ALU_NOP, ALU_DIFF, ALU_HOUT, ALU_Y, ALU_ACC_D2, ALU_D1, ALU_ACC, ALU_D2,
    ALU_SCALE, ALU_C0, ALU_C1, ALU_C2, ALU_C3, ALU_C4
  } alu_op_t;

  typedef enum logic [2:0] {
    MA_T, MA_HOUT, MA_Y, MA_SCALE, MA_ISCALE, MA_FP
  } ma_sel_t;

  typedef enum logic [3:0] {
    MB_HP, MB_RECIP, MB_B0_SPAN, MB_B1, MB_B2, MB_A1, MB_A2,
    MB_C0, MB_C1, MB_C2, MB_C3, MB_C4
  } mb_sel_t;

  typedef enum logic {CH_L, CH_R} ch_t;

  typedef struct packed {
    seq_op_t         seq;
    logic [PC_W-1:0] target;
    alu_op_t         alu;
    ch_t             alu_ch;
    ma_sel_t         ma;
    mb_sel_t         mb;
    ch_t             mul_ch;
  } ctrl_word_t;

  typedef struct packed {
    logic    run;
    alu_op_t alu;
    ch_t     alu_ch;
    ma_sel_t ma;
    mb_sel_t mb;
    ch_t     mul_ch;
  } smdb_ctl_t;

  typedef struct packed {
    logic mute;
    logic coef_ok;
  } smdb_cond_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } smdb_res_t;

  function automatic ctrl_word_t mk(seq_op_t s, logic [PC_W-1:0] tgt, alu_op_t a,
                                    ch_t ach, ma_sel_t ma, mb_sel_t mb, ch_t mch);
    ctrl_word_t w;
    w.seq    = s;
    w.target = tgt;
    w.alu    = a;
    w.alu_ch = ach;
    w.ma     = ma;
    w.mb     = mb;
    w.mul_ch = mch;
    return w;
  endfunction

  // Microprogram. The multiplier result is registered, so an ALU step
  // consumes the product issued one step earlier.
  function automatic ctrl_word_t rom_word(logic [PC_W-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      // dispatch
      PC_W'(0):  w = mk(SEQ_JMP_MUTE, PC_MUTE, ALU_NOP, CH_L, MA_T, MB_HP, CH_L);
      PC_W'(1):  w = mk(SEQ_JMP_COEF, PC_MAIN, ALU_NOP, CH_L, MA_FP, MB_RECIP, CH_L);
      // coefficient recompute
      PC_W'(2):  w = mk(SEQ_NEXT, '0, ALU_SCALE, CH_L, MA_T, MB_HP, CH_L);
      PC_W'(3):  w = mk(SEQ_NEXT, '0, ALU_NOP, CH_L, MA_ISCALE, MB_B0_SPAN, CH_L);
      PC_W'(4):  w = mk(SEQ_NEXT, '0, ALU_C0, CH_L, MA_SCALE, MB_B1, CH_L);
      PC_W'(5):  w = mk(SEQ_NEXT, '0, ALU_C1, CH_L, MA_SCALE, MB_B2, CH_L);
      PC_W'(6):  w = mk(SEQ_NEXT, '0, ALU_C2, CH_L, MA_SCALE, MB_A1, CH_L);
      PC_W'(7):  w = mk(SEQ_NEXT, '0, ALU_C3, CH_L, MA_SCALE, MB_A2, CH_L);
      PC_W'(8):  w = mk(SEQ_NEXT, '0, ALU_C4, CH_L, MA_T, MB_HP, CH_L);
      // DC blocker, both channels interleaved
      PC_W'(9):  w = mk(SEQ_NEXT, '0, ALU_DIFF, CH_L, MA_T, MB_HP, CH_L);
      PC_W'(10): w = mk(SEQ_NEXT, '0, ALU_DIFF, CH_R, MA_T, MB_HP, CH_L);
      PC_W'(11): w = mk(SEQ_NEXT, '0, ALU_HOUT, CH_L, MA_T, MB_HP, CH_R);
      PC_W'(12): w = mk(SEQ_NEXT, '0, ALU_HOUT, CH_R, MA_HOUT, MB_C0, CH_L);
      // biquad, left
      PC_W'(13): w = mk(SEQ_NEXT, '0, ALU_Y, CH_L, MA_HOUT, MB_C1, CH_L);
      PC_W'(14): w = mk(SEQ_NEXT, '0, ALU_ACC_D2, CH_L, MA_Y, MB_C3, CH_L);
      PC_W'(15): w = mk(SEQ_NEXT, '0, ALU_D1, CH_L, MA_HOUT, MB_C2, CH_L);
      PC_W'(16): w = mk(SEQ_NEXT, '0, ALU_ACC, CH_L, MA_Y, MB_C4, CH_L);
      PC_W'(17): w = mk(SEQ_NEXT, '0, ALU_D2, CH_L, MA_HOUT, MB_C0, CH_R);
      // biquad, right
      PC_W'(18): w = mk(SEQ_NEXT, '0, ALU_Y, CH_R, MA_HOUT, MB_C1, CH_R);
      PC_W'(19): w = mk(SEQ_NEXT, '0, ALU_ACC_D2, CH_R, MA_Y, MB_C3, CH_R);
      PC_W'(20): w = mk(SEQ_NEXT, '0, ALU_D1, CH_R, MA_HOUT, MB_C2, CH_R);
      PC_W'(21): w = mk(SEQ_NEXT, '0, ALU_ACC, CH_R, MA_Y, MB_C4, CH_R);
      PC_W'(22): w = mk(SEQ_DONE, '0, ALU_D2, CH_R, MA_T, MB_HP, CH_L);
      // both sources off
      default:   w = mk(SEQ_DONE_ZERO, '0, ALU_NOP, CH_L, MA_T, MB_HP, CH_L);
    endcase
    return w;
  endfunction

endpackage

// File: rtl/smdb_seq.sv
// Microcode sequencer: step counter, ROM fetch, jumps and the input handshake.
// Depends on smdb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smdb_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  smdb_pkg::smdb_cond_t  cond,
  input  logic                  out_busy,
  output smdb_pkg::smdb_ctl_t   ctl,
  output smdb_pkg::smdb_res_t   res
);

  smdb_pkg::seq_state_t state_r, state_nxt;
  logic [smdb_pkg::PC_W-1:0] pc_r, pc_nxt;
  smdb_pkg::ctrl_word_t cw;
  logic is_done, stall, step_en, in_fire;

  assign cw      = smdb_pkg::rom_word(pc_r);
  assign is_done = (cw.seq == smdb_pkg::SEQ_DONE) || (cw.seq == smdb_pkg::SEQ_DONE_ZERO);
  // hold the last step while the output word is still pending
  assign stall   = is_done && out_busy;
  assign step_en = (state_r == smdb_pkg::SQ_RUN) && !stall;
  assign in_fire = in_tvalid && (state_r == smdb_pkg::SQ_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smdb_pkg::SQ_IDLE: if (in_fire) state_nxt = smdb_pkg::SQ_RUN;
      smdb_pkg::SQ_RUN:  if (step_en && is_done) state_nxt = smdb_pkg::SQ_IDLE;
      default:           state_nxt = smdb_pkg::SQ_IDLE;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    priority if (in_fire) begin
      pc_nxt = '0;
    end else if (step_en) begin
      unique case (cw.seq)
        smdb_pkg::SEQ_NEXT:     pc_nxt = pc_r + smdb_pkg::PC_W'(1);
        smdb_pkg::SEQ_JMP_MUTE: pc_nxt = cond.mute ? cw.target : pc_r + smdb_pkg::PC_W'(1);
        smdb_pkg::SEQ_JMP_COEF: pc_nxt = cond.coef_ok ? cw.target
                                                      : pc_r + smdb_pkg::PC_W'(1);
        default:                pc_nxt = pc_r;
      endcase
    end
  end

  always_comb begin
    in_tready  = (state_r == smdb_pkg::SQ_IDLE);
    ctl.run    = step_en;
    ctl.alu    = cw.alu;
    ctl.alu_ch = cw.alu_ch;
    ctl.ma     = cw.ma;
    ctl.mb     = cw.mb;
    ctl.mul_ch = cw.mul_ch;
    res.valid  = step_en && is_done;
    res.zero   = (cw.seq == smdb_pkg::SEQ_DONE_ZERO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smdb_pkg::SQ_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  `SMDB_ASSERT_NEXT(a_start_at_zero, in_fire, (state_r == smdb_pkg::SQ_RUN) && (pc_r == '0), "accepted word did not start the program at step zero")
  `SMDB_ASSERT_IMPL(a_pc_in_rom, state_r == smdb_pkg::SQ_RUN, pc_r <= smdb_pkg::PC_LAST, "step counter ran past the program")
  `SMDB_ASSERT_NEXT(a_stall_holds, (state_r == smdb_pkg::SQ_RUN) && stall, $stable(pc_r) && (state_r == smdb_pkg::SQ_RUN), "step counter moved while the result stalled")

endmodule

// File: rtl/smdb_datapath.sv
// Datapath: input mix, shared 32x24 multiplier, filter state and coefficients.
// Depends on smdb_pkg; driven by the control word of smdb_seq.
module smdb_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  smdb_pkg::smdb_ctl_t                  ctl,
  input  logic                                 load,
  input  logic signed [smdb_pkg::SMP_W-1:0]    fm_left,
  input  logic signed [smdb_pkg::SMP_W-1:0]    fm_right,
  input  logic        [smdb_pkg::PSG_W-1:0]    psg_sample,
  input  logic                                 fm_en,
  input  logic                                 psg_en,
  input  logic        [smdb_pkg::PCT_W-1:0]    filter_pct,
  input  logic                                 pct_wr,
  output logic                                 coef_ok,
  output logic        [smdb_pkg::SMP_W-1:0]    y_left,
  output logic        [smdb_pkg::SMP_W-1:0]    y_right
);

  localparam int DW = smdb_pkg::DATA_W;
  localparam int CW = smdb_pkg::COEF_W;
  localparam int BW = smdb_pkg::MB_W;
  localparam int MW = smdb_pkg::MIX_W;

  // mix
  logic signed [MW-1:0] psg_c;
  logic signed [MW:0]   psg_m3, psg_q;
  logic signed [18:0]   fm7_l, fm7_r, fms_l, fms_r;
  logic signed [MW-1:0] mix_l, mix_r;

  // state and temporaries
  logic signed [DW-1:0] x_l_r, x_r_r, hin_l_r, hin_r_r, hout_l_r, hout_r_r;
  logic signed [DW-1:0] d1_l_r, d1_r_r, d2_l_r, d2_r_r;
  logic signed [DW-1:0] t_l_r, t_r_r, y_l_r, y_r_r, acc_r;
  logic        [smdb_pkg::PROD_W-1:0] p_r;
  logic signed [CW-1:0] scale_r, c0_r, c1_r, c2_r, c3_r, c4_r;
  logic                 dirty_r;

  // operand and result wires
  logic signed [DW-1:0] mul_a, hout_m, t_m, y_m, iscale;
  logic signed [BW-1:0] mul_b;
  logic signed [55:0]   prod_full;
  logic signed [DW-1:0] p_hi, p_lo;
  logic signed [DW-1:0] x_a, hin_a, hout_a, d1_a, d2_a;
  logic signed [DW-1:0] diff_nxt, y_nxt, accd2_nxt, sub_nxt, c0_full;

  // PSG: center, times 3, divide by 8 toward zero
  assign psg_c  = $signed({2'b00, psg_sample}) - smdb_pkg::K_PSG_MID;
  assign psg_m3 = $signed({psg_c[MW-1], psg_c}) + $signed({psg_c, 1'b0});
  assign psg_q  = (psg_m3 + (psg_m3[MW] ? 18'sd7 : 18'sd0)) >>> 3;
  // FM: times 7, floor shift by 3
  assign fm7_l  = $signed({fm_left, 3'b000}) - $signed({{3{fm_left[15]}}, fm_left});
  assign fm7_r  = $signed({fm_right, 3'b000}) - $signed({{3{fm_right[15]}}, fm_right});
  assign fms_l  = fm7_l >>> 3;
  assign fms_r  = fm7_r >>> 3;
  assign mix_l  = (fm_en ? fms_l[MW-1:0] : '0) + (psg_en ? psg_q[MW-1:0] : '0);
  assign mix_r  = (fm_en ? fms_r[MW-1:0] : '0) + (psg_en ? psg_q[MW-1:0] : '0);

  assign hout_m = (ctl.mul_ch == smdb_pkg::CH_L) ? hout_l_r : hout_r_r;
  assign t_m    = (ctl.mul_ch == smdb_pkg::CH_L) ? t_l_r : t_r_r;
  assign y_m    = (ctl.mul_ch == smdb_pkg::CH_L) ? y_l_r : y_r_r;
  assign iscale = smdb_pkg::K_ONE - DW'(scale_r);

  always_comb begin
    unique case (ctl.ma)
      smdb_pkg::MA_T:      mul_a = t_m;
      smdb_pkg::MA_HOUT:   mul_a = hout_m;
      smdb_pkg::MA_Y:      mul_a = y_m;
      smdb_pkg::MA_SCALE:  mul_a = DW'(scale_r);
      smdb_pkg::MA_ISCALE: mul_a = iscale;
      smdb_pkg::MA_FP:     mul_a = $signed({{(DW - smdb_pkg::PCT_W){1'b0}}, filter_pct});
      default:             mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.mb)
      smdb_pkg::MB_HP:      mul_b = smdb_pkg::K_DCB_POLE;
      smdb_pkg::MB_RECIP:   mul_b = smdb_pkg::K_RECIP;
      smdb_pkg::MB_B0_SPAN: mul_b = smdb_pkg::K_B0_SPAN;
      smdb_pkg::MB_B1:      mul_b = smdb_pkg::K_B1;
      smdb_pkg::MB_B2:      mul_b = smdb_pkg::K_B2;
      smdb_pkg::MB_A1:      mul_b = smdb_pkg::K_A1;
      smdb_pkg::MB_A2:      mul_b = smdb_pkg::K_A2;
      smdb_pkg::MB_C0:      mul_b = BW'(c0_r);
      smdb_pkg::MB_C1:      mul_b = BW'(c1_r);
      smdb_pkg::MB_C2:      mul_b = BW'(c2_r);
      smdb_pkg::MB_C3:      mul_b = BW'(c3_r);
      smdb_pkg::MB_C4:      mul_b = BW'(c4_r);
      default:              mul_b = '0;
    endcase
  end

  assign prod_full = 56'(mul_a) * 56'(mul_b);
  assign p_hi      = $signed(p_r[47:16]);   // product >>> 16, wrapped to 32 bits
  assign p_lo      = $signed(p_r[31:0]);

  assign x_a    = (ctl.alu_ch == smdb_pkg::CH_L) ? x_l_r : x_r_r;
  assign hin_a  = (ctl.alu_ch == smdb_pkg::CH_L) ? hin_l_r : hin_r_r;
  assign hout_a = (ctl.alu_ch == smdb_pkg::CH_L) ? hout_l_r : hout_r_r;
  assign d1_a   = (ctl.alu_ch == smdb_pkg::CH_L) ? d1_l_r : d1_r_r;
  assign d2_a   = (ctl.alu_ch == smdb_pkg::CH_L) ? d2_l_r : d2_r_r;

  assign diff_nxt  = hout_a + x_a - hin_a;
  assign y_nxt     = p_hi + (d1_a >>> 16);
  assign accd2_nxt = p_lo + d2_a;
  assign sub_nxt   = acc_r - p_lo;
  assign c0_full   = smdb_pkg::K_B0 + p_hi;

  // filter history and coefficient flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hin_l_r  <= '0;
      hin_r_r  <= '0;
      hout_l_r <= '0;
      hout_r_r <= '0;
      d1_l_r   <= '0;
      d1_r_r   <= '0;
      d2_l_r   <= '0;
      d2_r_r   <= '0;
      dirty_r  <= 1'b1;
    end else begin
      if (ctl.run) begin
        unique case (ctl.alu)
          smdb_pkg::ALU_DIFF: begin
            if (ctl.alu_ch == smdb_pkg::CH_L) hin_l_r <= x_l_r;
            else hin_r_r <= x_r_r;
          end
          smdb_pkg::ALU_HOUT: begin
            if (ctl.alu_ch == smdb_pkg::CH_L) hout_l_r <= p_hi;
            else hout_r_r <= p_hi;
          end
          smdb_pkg::ALU_D1: begin
            if (ctl.alu_ch == smdb_pkg::CH_L) d1_l_r <= sub_nxt;
            else d1_r_r <= sub_nxt;
          end
          smdb_pkg::ALU_D2: begin
            if (ctl.alu_ch == smdb_pkg::CH_L) d2_l_r <= sub_nxt;
            else d2_r_r <= sub_nxt;
          end
          smdb_pkg::ALU_C4: dirty_r <= 1'b0;
          default: ;
        endcase
      end
      // new percent: recompute coefficients on the next word
      if (pct_wr) dirty_r <= 1'b1;
    end
  end

  // payload: mixed input, product, temporaries, coefficients
  always_ff @(posedge clk) begin
    if (load) begin
      x_l_r <= DW'(mix_l);
      x_r_r <= DW'(mix_r);
    end
    if (ctl.run) begin
      p_r <= prod_full[smdb_pkg::PROD_W-1:0];
      unique case (ctl.alu)
        smdb_pkg::ALU_DIFF: begin
          if (ctl.alu_ch == smdb_pkg::CH_L) t_l_r <= diff_nxt;
          else t_r_r <= diff_nxt;
        end
        smdb_pkg::ALU_Y: begin
          if (ctl.alu_ch == smdb_pkg::CH_L) y_l_r <= y_nxt;
          else y_r_r <= y_nxt;
        end
        smdb_pkg::ALU_ACC_D2: acc_r   <= accd2_nxt;
        smdb_pkg::ALU_ACC:    acc_r   <= p_lo;
        smdb_pkg::ALU_SCALE:  scale_r <= $signed(p_r[29:12]);   // (fp*M) >> 12
        smdb_pkg::ALU_C0:     c0_r    <= c0_full[CW-1:0];
        smdb_pkg::ALU_C1:     c1_r    <= $signed(p_r[33:16]);
        smdb_pkg::ALU_C2:     c2_r    <= $signed(p_r[33:16]);
        smdb_pkg::ALU_C3:     c3_r    <= $signed(p_r[33:16]);
        smdb_pkg::ALU_C4:     c4_r    <= $signed(p_r[33:16]);
        default: ;
      endcase
    end
  end

  assign coef_ok = !dirty_r;
  assign y_left  = y_l_r[smdb_pkg::SMP_W-1:0];
  assign y_right = y_r_r[smdb_pkg::SMP_W-1:0];

endmodule

// File: rtl/stereo_mix_dc_block_biquad.sv
// Stereo mixer, DC blocker and biquad low-pass; top level with config and output word.
// Depends on smdb_pkg, smdb_seq, smdb_datapath and assert_macros.svh.
// The first word after reset or a filter_percent write also recomputes the
// coefficients; with both sources off the program issues a zero word instead.
// Words are taken one at a time: the next is accepted once the last is finished.
// Reset (rst_n low, synchronous): filter history cleared, enables 1, percent 50.
`include "assert_macros.svh"

module stereo_mix_dc_block_biquad (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // fm_left[15:0], fm_right[31:16], psg_sample[46:32]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_left[15:0], out_right[31:16]
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata
);

  localparam int SW = smdb_pkg::SMP_W;

  logic                       fm_en_r, psg_en_r;
  logic [smdb_pkg::PCT_W-1:0] pct_r;
  logic                       pct_wr, in_fire, out_busy, coef_ok;
  logic [SW-1:0]              y_left, y_right;
  logic                       out_valid_r;
  logic [2*SW-1:0]            out_data_r;

  smdb_pkg::smdb_ctl_t  ctl;
  smdb_pkg::smdb_cond_t cond;
  smdb_pkg::smdb_res_t  res;

  // Config regs. Writes must arrive only while idle (unchecked); unknown index dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fm_en_r  <= 1'b1;
      psg_en_r <= 1'b1;
      pct_r    <= smdb_pkg::PCT_W'(50);
    end else if (cfg_we) begin
      unique case (smdb_pkg::cfg_idx_t'(cfg_index))
        smdb_pkg::CFG_FM_ENABLE:  fm_en_r  <= cfg_wdata[0];
        smdb_pkg::CFG_PSG_ENABLE: psg_en_r <= cfg_wdata[0];
        smdb_pkg::CFG_FILTER_PCT: pct_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign pct_wr = cfg_we && (cfg_index == smdb_pkg::CFG_FILTER_PCT);

  // Input word is accepted whenever the sequencer is idle, even with a result
  // still waiting in the output register.
  assign in_fire  = in_tvalid && in_tready;
  // Final step stalls while the output register holds an untaken word.
  assign out_busy = out_valid_r && !out_tready;

  assign cond.mute    = !fm_en_r && !psg_en_r;
  assign cond.coef_ok = coef_ok;

  smdb_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cond      (cond),
    .out_busy  (out_busy),
    .ctl       (ctl),
    .res       (res)
  );

  smdb_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .load       (in_fire),
    .fm_left    ($signed(in_tdata[15:0])),
    .fm_right   ($signed(in_tdata[31:16])),
    .psg_sample (in_tdata[46:32]),
    .fm_en      (fm_en_r),
    .psg_en     (psg_en_r),
    .filter_pct (pct_r),
    .pct_wr     (pct_wr),
    .coef_ok    (coef_ok),
    .y_left     (y_left),
    .y_right    (y_right)
  );

  // Output register: load on the final step, drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r <= res.zero ? '0 : {y_right, y_left};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SMDB_ASSERT_IMPL(a_no_overwrite, res.valid, !out_valid_r || out_tready, "result overwrote an untaken output word")
  `SMDB_ASSERT_IMPL(a_zero_only_muted, res.valid && res.zero, !fm_en_r && !psg_en_r, "zero result issued with a source enabled")

endmodule

// File: verif/tb.sv
// Testbench for stereo_mix_dc_block_biquad: directed and random sample words are
// checked against a fixed-point model of the mixer, DC blocker and low-pass kept here.
// Depends on smdb_pkg (register indexes) and the RTL top level.
`timescale 1ns / 1ps

module tb;

  // Index past the last register; writes to it must be ignored.
  localparam logic [1:0] CFG_NONE = 2'd3;

  // Filter constants, 16.16 fixed point
  localparam longint DCB_POLE = 65208;
  localparam longint LP_B0    = 7680;
  localparam longint LP_B1    = 15360;
  localparam longint LP_B2    = 7680;
  localparam longint LP_A1    = -24576;
  localparam longint LP_A2    = 1024;
  localparam longint Q16_ONE  = 65536;
  localparam longint PSG_MID  = 16384;

  // Settle wait, with margin over the longest coefficient recompute.
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 3000;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // fm_left[15:0], fm_right[31:16], psg_sample[46:32]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // out_left[15:0], out_right[31:16]
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_wdata = '0;

  stereo_mix_dc_block_biquad u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Mixer model: register copies and filter history, both channels (0 left, 1 right)
  // ---------------------------------------------------------------------------
  logic       mix_fm  = 1'b1;
  logic       mix_psg = 1'b1;
  logic [6:0] lp_pct  = 7'd50;
  longint     hp_x1[2] = '{0, 0};
  longint     hp_y1[2] = '{0, 0};
  longint     lp_z1[2] = '{0, 0};
  longint     lp_z2[2] = '{0, 0};

  logic [31:0] mix_expected[$];   // {right, left} per result word, oldest first
  int          mix_errors = 0;

  function automatic longint wrap32(input longint v);
    return longint'(signed'(v[31:0]));
  endfunction

  // Advance the filter state by one sample pair and return {right, left}.
  function automatic logic [31:0] mix_filter_predict(input logic signed [15:0] fl,
                                                     input logic signed [15:0] fr,
                                                     input logic [14:0] psg);
    longint     src[2];
    longint     psg_c, scale, c0, c1, c2, c3, c4, d, x, y;
    logic [15:0] res[2];
    int         ch;
    // Muted: zero out, history untouched
    if (!mix_fm && !mix_psg) return '0;
    // C division truncates toward zero, which SV signed division also does
    psg_c = ((longint'(psg) - PSG_MID) * 3) / 8;
    src[0] = 0;
    src[1] = 0;
    if (mix_fm) begin
      src[0] = (longint'(fl) * 7) >>> 3;
      src[1] = (longint'(fr) * 7) >>> 3;
    end
    if (mix_psg) begin
      src[0] = src[0] + psg_c;
      src[1] = src[1] + psg_c;
    end
    // Percent above 100 extrapolates; nothing is clamped
    scale = (Q16_ONE * longint'(lp_pct)) / 100;
    c0 = wrap32(LP_B0 + (((Q16_ONE - LP_B0) * (Q16_ONE - scale)) >>> 16));
    c1 = (LP_B1 * scale) >>> 16;
    c2 = (LP_B2 * scale) >>> 16;
    c3 = (LP_A1 * scale) >>> 16;
    c4 = (LP_A2 * scale) >>> 16;
    for (ch = 0; ch < 2; ch++) begin
      d = wrap32(hp_y1[ch] + src[ch] - hp_x1[ch]);
      x = wrap32((DCB_POLE * d) >>> 16);
      hp_x1[ch] = src[ch];
      hp_y1[ch] = x;
      y = wrap32(((c0 * x) >>> 16) + (lp_z1[ch] >>> 16));
      lp_z1[ch] = wrap32(c1 * x + lp_z2[ch] - c3 * y);
      lp_z2[ch] = wrap32(c2 * x - c4 * y);
      res[ch] = y[15:0];
    end
    return {res[1], res[0]};
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: when paced, bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  bit tx_paced = 1'b1;
  int tx_burst_left = 0;
  int tx_gap;

  task automatic send_word(input logic signed [15:0] fl, input logic signed [15:0] fr,
                           input logic [14:0] psg);
    if (tx_paced && tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 16);
      tx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (tx_gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (tx_gap) @(posedge clk);
      end
    end
    if (tx_burst_left > 0) tx_burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, psg, fr, fl};
    do @(posedge clk); while (!in_tready);
    // Word taken at this edge: record what it must produce
    mix_expected.push_back(mix_filter_predict(fl, fr, psg));
  endtask

  // Drop valid, let every pending word drain, then give the block time to go idle.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; only called while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      smdb_pkg::CFG_FM_ENABLE:  mix_fm  = val[0];
      smdb_pkg::CFG_PSG_ENABLE: mix_psg = val[0];
      smdb_pkg::CFG_FILTER_PCT: lp_pct  = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_edge16();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return 16'sh0001;
    endcase
  endfunction

  function automatic logic [14:0] pick_edge_psg();
    case ($urandom_range(0, 4))
      0:       return 15'h0000;
      1:       return 15'h7FFF;
      2:       return 15'h4000;
      3:       return 15'h3FFF;
      default: return 15'h4001;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, plus a long hold on request
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_hold_left = 0;
  bit       rx_hold_req = 1'b0;
  int       rx_tick = 0;

  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(40, 400);
    end
    rx_mode_left--;
    rx_tick++;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:  out_tready <= 1'b1;
        RX_LIGHT: out_tready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: out_tready <= ($urandom_range(0, 3) == 0);
        default:  out_tready <= (rx_tick % 5 == 0);
      endcase
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (mix_expected.size() == 0) begin
        mix_errors++;
        $display("%0t: unexpected word, expected none, got %h", $time, out_tdata);
      end else begin
        want = mix_expected.pop_front();
        if (want[15:0] !== out_tdata[15:0]) begin
          mix_errors++;
          $display("%0t: out_left expected %0d got %0d", $time,
                   $signed(want[15:0]), $signed(out_tdata[15:0]));
        end
        if (want[31:16] !== out_tdata[31:16]) begin
          mix_errors++;
          $display("%0t: out_right expected %0d got %0d", $time,
                   $signed(want[31:16]), $signed(out_tdata[31:16]));
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either stream for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: both sources on, percent 50. Covers field extremes and the
  // PSG rounding toward zero just below and above the midpoint.
  task automatic test_reset_defaults();
    send_word(16'sh0000, 16'sh0000, 15'h4000);
    send_word(16'sh7FFF, 16'sh8000, 15'h7FFF);
    send_word(16'sh8000, 16'sh7FFF, 15'h0000);
    send_word(16'shFFFF, 16'sh0001, 15'h3FFF);
    send_word(16'sh0001, 16'shFFFF, 15'h4001);
    send_word(16'sh7FFF, 16'sh7FFF, 15'h7FFF);
  endtask

  // Each source alone, both off (zero out, history held), then both back on.
  task automatic test_source_select();
    settle();
    write_reg(smdb_pkg::CFG_PSG_ENABLE, 7'd0);
    send_word(16'sh8000, 16'sh7FFF, 15'h7FFF);
    send_word(16'sh7FFF, 16'sh8000, 15'h0000);
    send_word(16'shFFFF, 16'sh0001, 15'h4000);
    settle();
    write_reg(smdb_pkg::CFG_FM_ENABLE, 7'd0);
    write_reg(smdb_pkg::CFG_PSG_ENABLE, 7'd1);
    send_word(16'sh7FFF, 16'sh8000, 15'h0000);
    send_word(16'sh1234, 16'sh8765, 15'h7FFF);
    send_word(16'sh0000, 16'sh0000, 15'h3FFF);
    settle();
    write_reg(smdb_pkg::CFG_PSG_ENABLE, 7'd0);
    send_word(16'sh7FFF, 16'sh8000, 15'h7FFF);
    send_word(16'sh8000, 16'sh7FFF, 15'h0000);
    send_word(16'sh5A5A, 16'shA5A5, 15'h2AAA);
    settle();
    write_reg(smdb_pkg::CFG_FM_ENABLE, 7'd1);
    write_reg(smdb_pkg::CFG_PSG_ENABLE, 7'd1);
    send_word(16'sh0100, 16'shFF00, 15'h4100);
    send_word(16'sh8000, 16'sh8000, 15'h0000);
  endtask

  // Percent bypass, full, and the extrapolating top value; a write to the
  // unused index; an oversized value on a one-bit register.
  task automatic test_filter_extremes();
    settle();
    write_reg(smdb_pkg::CFG_FILTER_PCT, 7'd0);
    send_word(16'sh7FFF, 16'sh8000, 15'h7FFF);
    send_word(16'sh8000, 16'sh7FFF, 15'h0000);
    settle();
    write_reg(smdb_pkg::CFG_FILTER_PCT, 7'd100);
    send_word(16'sh7FFF, 16'sh8000, 15'h7FFF);
    send_word(16'sh0000, 16'sh0000, 15'h4000);
    settle();
    write_reg(smdb_pkg::CFG_FILTER_PCT, 7'd127);
    send_word(16'sh7FFF, 16'sh7FFF, 15'h7FFF);
    send_word(16'sh8000, 16'sh8000, 15'h0000);
    settle();
    write_reg(CFG_NONE, 7'd0);
    send_word(16'sh4000, 16'shC000, 15'h6000);
    settle();
    // Upper bits set, bit 0 clear: FM must turn off
    write_reg(smdb_pkg::CFG_FM_ENABLE, 7'h7E);
    send_word(16'sh7FFF, 16'sh8000, 15'h1000);
  endtask

  // Hold the receiver off for a long stretch while words keep coming, so the
  // block fills and has to stall its input.
  task automatic test_output_stall();
    settle();
    write_reg(smdb_pkg::CFG_FM_ENABLE, 7'd1);
    write_reg(smdb_pkg::CFG_PSG_ENABLE, 7'd1);
    write_reg(smdb_pkg::CFG_FILTER_PCT, 7'd75);
    rx_hold_req = 1'b1;
    tx_paced = 1'b0;
    repeat (25) send_word(16'($urandom), 16'($urandom), 15'($urandom));
    tx_paced = 1'b1;
  endtask

  // Random phases: fresh settings per phase, then a mix of full-range,
  // quiet, extreme and near-DC words to work the blocker and the biquad.
  task automatic test_random_mix();
    logic signed [15:0] fl, fr, dc_l, dc_r;
    logic [14:0]        psg, dc_p;
    logic [6:0]         pct;
    int                 n, sel;
    for (int phase = 0; phase < 10; phase++) begin
      settle();
      sel = $urandom_range(0, 9);
      // Upper data bits are junk on purpose; only bit 0 may count
      write_reg(smdb_pkg::CFG_FM_ENABLE,  {6'($urandom), (sel <= 7)});
      write_reg(smdb_pkg::CFG_PSG_ENABLE, {6'($urandom), (sel <= 5 || sel == 8)});
      case ($urandom_range(0, 9))
        0:       pct = 7'd0;
        1:       pct = 7'd100;
        2:       pct = 7'd127;
        3:       pct = 7'd1;
        default: pct = 7'($urandom_range(0, 127));
      endcase
      write_reg(smdb_pkg::CFG_FILTER_PCT, pct);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_NONE, 7'($urandom));
      dc_l = 16'($urandom);
      dc_r = 16'($urandom);
      dc_p = 15'($urandom);
      n = $urandom_range(90, 110);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            fl  = 16'($urandom);
            fr  = 16'($urandom);
            psg = 15'($urandom);
          end
          4, 5: begin
            fl  = 16'(int'($urandom_range(0, 1023)) - 512);
            fr  = 16'(int'($urandom_range(0, 1023)) - 512);
            psg = 15'(int'(PSG_MID) + int'($urandom_range(0, 255)) - 128);
          end
          6: begin
            fl  = pick_edge16();
            fr  = pick_edge16();
            psg = pick_edge_psg();
          end
          default: begin
            fl  = 16'(int'(dc_l) + int'($urandom_range(0, 15)) - 8);
            fr  = 16'(int'(dc_r) + int'($urandom_range(0, 15)) - 8);
            psg = 15'(int'(dc_p) + int'($urandom_range(0, 7)) - 4);
          end
        endcase
        send_word(fl, fr, psg);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_source_select();
    test_filter_extremes();
    test_output_stall();
    test_random_mix();
    settle();
    if (mix_errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
